// File: hdl/cdfs_pkg.sv
// Shared types and constants for the CDF table sampler.
// Used by the channel interfaces, the divider, the top level and the checker.
package cdfs_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DRAW_BITS_DEF   = 16;

  localparam int VAL_W   = 32;
  localparam int CDF_W   = 32;
  localparam int DRAW_W  = 16;
  localparam int CNT_W   = 9;
  localparam int MEAN_W  = 48;

  localparam logic [CDF_W-1:0] CDF_ONE = 32'd65536;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ACC   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic        rem_nz;
  } div_rsp_t;

endpackage

// File: hdl/cdfs_if.sv
// Valid/ready channel interfaces for the CDF table sampler.
// Depends on cdfs_pkg for field widths.
interface cdfs_in_if import cdfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [VAL_W-1:0]  entry_value;
  logic [CDF_W-1:0]  entry_cdf;
  logic [DRAW_W-1:0] draw;

  modport source (output valid, op, entry_value, entry_cdf, draw, input ready);
  modport sink   (input valid, op, entry_value, entry_cdf, draw, output ready);
endinterface

interface cdfs_out_if import cdfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VAL_W-1:0]         sample_value;
  logic [1:0]               status;
  logic [CNT_W-1:0]         entry_count;
  logic signed [MEAN_W-1:0] mean_value;

  modport source (output valid, sample_value, status, entry_count, mean_value, input ready);
  modport sink   (input valid, sample_value, status, entry_count, mean_value, output ready);
endinterface

// File: hdl/cdfs_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
// One quotient bit per cycle; depends on cdfs_pkg for the request and response types.
module cdfs_div import cdfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial   = {rem_r, dvd_r[63]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[31:0] : trial[31:0];
    dvd_nxt = {dvd_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      dvd_r  <= req.dividend;
      rem_r  <= '0;
      dsr_r  <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = dvd_r;
  assign rsp.rem_nz = rem_r != '0;

endmodule

// File: hdl/cdf_table_random_sampler_unit.sv
// CDF table sampler: holds (value, cdf) points in a table memory and draws samples by
// inverse-CDF lookup with linear interpolation. One item is handled at a time. For a
// sample, a shift-and-add division by 2^DRAW_BITS - 1 scales the draw into the cdf span,
// the scan reads one table entry per cycle through the memory's registered read port,
// and the bit-serial divider finishes the interpolation. A finished result waits in the
// output register while the next item is accepted.
module cdf_table_random_sampler_unit import cdfs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DRAW_BITS   = DRAW_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  cdfs_in_if.sink  in_ch,
  cdfs_out_if.source out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DMASK = 32'((64'd1 << DRAW_BITS) - 64'd1);
  localparam logic [63:0] DMASK64 = (64'd1 << DRAW_BITS) - 64'd1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_AMUL   = 11'b00000000010,
    S_AACC   = 11'b00000000100,
    S_XMUL   = 11'b00000001000,
    S_XSTART = 11'b00000010000,
    S_XDIV   = 11'b00000100000,
    S_SRCH   = 11'b00001000000,
    S_IMUL   = 11'b00010000000,
    S_ISTART = 11'b00100000000,
    S_IWAIT  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic [31:0]        cdf_low_r, cdf_low_nxt, cdf_high_r, cdf_high_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [31:0]        prev_v_r, prev_v_nxt, prev_c_r, prev_c_nxt;
  logic [31:0]        v_r, v_nxt, c_r, c_nxt;
  logic [15:0]        d_r, d_nxt;
  logic [64:0]        prod_r;
  logic [31:0]        x_r, x_nxt, x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [63:0]        xr_r, xr_nxt;
  logic               neg_r, neg_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [31:0]        res_sample_r, res_sample_nxt;
  status_t            res_status_r, res_status_nxt;

  logic                     out_valid_r;
  logic [31:0]              out_sample_r;
  logic [1:0]               out_status_r;
  logic [CNT_W-1:0]         out_count_r;
  logic signed [MEAN_W-1:0] out_mean_r;

  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_data_r;
  logic [AW-1:0] raddr;
  logic        we;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic               accept, load_out;
  logic [62:0]        tmag;
  logic signed [63:0] term;
  logic signed [64:0] sum65;
  logic [63:0]        mag;
  logic [MEAN_W-1:0]  mshift;
  logic signed [MEAN_W-1:0] mean_val;
  logic [31:0]        rd_cdf, rd_val;
  logic [32:0]        ysum;
  logic [64:0]        qa;
  logic [32:0]        psum;
  logic [31:0]        interp_res;
  logic [31:0]        cnt32;
  logic [63:0]        xa, xb;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == S_IDLE;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign rd_cdf   = rd_data_r[31:0];
  assign rd_val   = rd_data_r[63:32];
  assign raddr    = idx_r[AW-1:0];
  assign we       = state_r == S_AACC;

  always_ff @(posedge clk) begin
    if (we) mem[count_r[AW-1:0]] <= {v_r, c_r};
    rd_data_r <= mem[raddr];
  end

  // Shared multiplier operands, selected by the step that needs them.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_AMUL: begin
        mul_a = {1'b0, v_r} + {1'b0, prev_v_r};
        mul_b = (c_r >= prev_c_r) ? c_r - prev_c_r : prev_c_r - c_r;
      end
      S_XMUL: begin
        mul_a = {17'd0, d_r};
        mul_b = cdf_high_r - cdf_low_r;
      end
      S_IMUL: begin
        mul_a = {1'b0, x_r - x1_r};
        mul_b = (y2_r >= y1_r) ? y2_r - y1_r : y1_r - y2_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_AMUL || state_r == S_XMUL || state_r == S_IMUL)
      prod_r <= 65'(mul_a * mul_b);
  end

  always_comb begin
    div_req.start    = state_r == S_ISTART;
    div_req.dividend = prod_r[63:0];
    div_req.divisor  = x2_r - x1_r;
  end

  cdfs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Division by 2^DRAW_BITS - 1: the high part folds onto the low part until it is gone.
  always_comb begin
    xa = xr_r >> DRAW_BITS;
    xb = xr_r & DMASK64;
  end

  // Mean term saturates at the signed 64-bit limit before the saturating add.
  always_comb begin
    tmag  = (prod_r[64:63] != 2'b00) ? '1 : prod_r[62:0];
    term  = (c_r < prev_c_r) ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    sum65 = {acc_r[63], acc_r} + {term[63], term};
  end

  always_comb begin
    mag      = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    mshift   = {1'b0, mag[63:17]};
    mean_val = acc_r[63] ? -$signed(mshift) : $signed(mshift);
  end

  // Interpolation finish; a falling segment rounds the step up so the result truncates.
  always_comb begin
    ysum = {1'b0, y1_r} + {1'b0, rd_val};
    qa   = {1'b0, div_rsp.quot} + {64'd0, div_rsp.rem_nz};
    psum = {1'b0, y1_r} + {1'b0, div_rsp.quot[31:0]};
    if (neg_r)
      interp_res = (qa >= {33'd0, y1_r}) ? '0 : y1_r - qa[31:0];
    else
      interp_res = (div_rsp.quot[63:32] != '0 || psum[32]) ? '1 : psum[31:0];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cdf_low_nxt    = cdf_low_r;
    cdf_high_nxt   = cdf_high_r;
    acc_nxt        = acc_r;
    prev_v_nxt     = prev_v_r;
    prev_c_nxt     = prev_c_r;
    v_nxt          = v_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    x_nxt          = x_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    x2_nxt         = x2_r;
    y2_nxt         = y2_r;
    xr_nxt         = xr_r;
    neg_nxt        = neg_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    res_sample_nxt = res_sample_r;
    res_status_nxt = res_status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          v_nxt = in_ch.entry_value;
          c_nxt = in_ch.entry_cdf;
          d_nxt = in_ch.draw & DMASK[15:0];
          res_sample_nxt = '0;
          case (in_ch.op)
            OP_CLEAR: begin
              count_nxt      = '0;
              cdf_low_nxt    = '0;
              cdf_high_nxt   = CDF_ONE;
              acc_nxt        = '0;
              prev_v_nxt     = '0;
              prev_c_nxt     = '0;
              res_status_nxt = ST_ACC;
              state_nxt      = S_DONE;
            end
            OP_APPEND: begin
              if (count_r >= DEPTH_C) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                res_status_nxt = ST_ACC;
                state_nxt      = S_AMUL;
              end
            end
            default: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                res_status_nxt = ST_OK;
                state_nxt      = S_XMUL;
              end
            end
          endcase
        end
      end
      S_AMUL: state_nxt = S_AACC;
      S_AACC: begin
        if (sum65[64] != sum65[63])
          acc_nxt = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
          acc_nxt = sum65[63:0];
        prev_v_nxt = v_r;
        prev_c_nxt = c_r;
        count_nxt  = count_r + CW'(1);
        if (c_r < cdf_low_r) cdf_low_nxt = c_r;
        if (c_r > cdf_high_r) cdf_high_nxt = c_r;
        state_nxt = S_DONE;
      end
      S_XMUL:   state_nxt = S_XSTART;
      S_XSTART: begin
        xr_nxt    = prod_r[63:0];
        x_nxt     = '0;
        state_nxt = S_XDIV;
      end
      S_XDIV: begin
        if (xa == '0) begin
          // The leftover is at most the divisor; equal to it means one more unit.
          x_nxt     = cdf_low_r + x_r + ((xb == DMASK64) ? 32'd1 : 32'd0);
          x1_nxt    = '0;
          y1_nxt    = '0;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SRCH;
        end else begin
          x_nxt  = x_r + xa[31:0];
          xr_nxt = xa + xb;
        end
      end
      S_SRCH: begin
        // Reads are issued one per cycle; data for the previous address is checked here.
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (x_r <= rd_cdf) begin
            x2_nxt  = rd_cdf;
            y2_nxt  = rd_val;
            neg_nxt = rd_val < y1_r;
            if (x1_r == rd_cdf) begin
              res_sample_nxt = ysum[32:1];
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_IMUL;
            end
          end else begin
            x1_nxt = rd_cdf;
            y1_nxt = rd_val;
          end
        end else if (idx_r >= count_r) begin
          // Past the end of the table: the last value read stands.
          res_sample_nxt = y1_r;
          state_nxt      = S_DONE;
        end
      end
      S_IMUL:   state_nxt = S_ISTART;
      S_ISTART: state_nxt = S_IWAIT;
      S_IWAIT: begin
        if (div_rsp.done) begin
          res_sample_nxt = interp_res;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      cdf_low_r  <= '0;
      cdf_high_r <= CDF_ONE;
      acc_r      <= '0;
      prev_v_r   <= '0;
      prev_c_r   <= '0;
      pend_r     <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      cdf_low_r  <= cdf_low_nxt;
      cdf_high_r <= cdf_high_nxt;
      acc_r      <= acc_nxt;
      prev_v_r   <= prev_v_nxt;
      prev_c_r   <= prev_c_nxt;
      pend_r     <= pend_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    c_r          <= c_nxt;
    d_r          <= d_nxt;
    x_r          <= x_nxt;
    x1_r         <= x1_nxt;
    y1_r         <= y1_nxt;
    x2_r         <= x2_nxt;
    y2_r         <= y2_nxt;
    xr_r         <= xr_nxt;
    neg_r        <= neg_nxt;
    res_sample_r <= res_sample_nxt;
    res_status_r <= res_status_nxt;
  end

  assign cnt32 = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= res_sample_r;
      out_status_r <= res_status_r;
      out_count_r  <= cnt32[CNT_W-1:0];
      out_mean_r   <= mean_val;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = out_sample_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_count  = out_count_r;
  assign out_ch.mean_value   = out_mean_r;

endmodule

// File: hdl/cdfs_checker.sv
// Port-level checks for the CDF table sampler, bound to the top level.
// Depends on cdfs_pkg for the status codes.
module cdfs_assert_checker import cdfs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] sample_value,
  input logic [1:0]       status,
  input logic [CNT_W-1:0] entry_count
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(status))
    else $error("result beat changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> entry_count == '0 && sample_value == '0)
    else $error("empty status with entries or nonzero sample");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> entry_count == CNT_W'(TABLE_DEPTH) && sample_value == '0)
    else $error("full status with wrong count or nonzero sample");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OK |-> entry_count != '0)
    else $error("sample delivered from an empty table");

endmodule

bind cdf_table_random_sampler_unit cdfs_assert_checker #(.TABLE_DEPTH(TABLE_DEPTH))
  u_cdfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sample_value (out_ch.sample_value),
  .status       (out_ch.status),
  .entry_count  (out_ch.entry_count)
);

// File: verif/cdfs_tb_if.sv
// Testbench file for the sampler's channel interfaces; it defines none.
// The RTL interfaces in hdl/cdfs_if.sv are the ones bound to the block; this file holds only a timescale.
`timescale 1ns / 100ps

// File: verif/cdfs_checker.sv
// Checker for the CDF table sampler: watches both channels, predicts each result
// from accepted input beats and compares field by field. Depends on cdfs_pkg and cdfs_if.
`timescale 1ns / 100ps
module cdfs_checker import cdfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cdfs_in_if  in_ch,
  cdfs_out_if out_ch,
  output int  fail_count,
  output int  pending,
  output int  samples_seen,
  output int  fulls_seen
);
  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic [8:0]  cnt;
    logic [47:0] mean;
  } result_t;

  localparam longint I64_MAX = 64'sh7fffffffffffffff;
  localparam longint I64_MIN = 64'sh8000000000000000;

  logic [31:0] tab_val[TABLE_DEPTH_DEF];
  logic [31:0] tab_cdf[TABLE_DEPTH_DEF];
  int unsigned n_pts;
  logic [31:0] span_lo, span_hi, prev_v, prev_c;
  longint      mean_acc;
  result_t     expected_q[$];

  function automatic logic [31:0] lerp(logic [31:0] x, logic [31:0] x1, logic [31:0] y1,
                                       logic [31:0] x2, logic [31:0] y2);
    logic [63:0] dxm, dym, den, prod, q;
    logic        neg;
    if (x1 == x2) return 32'((64'(y1) + 64'(y2)) >> 1);
    dxm = x >= x1 ? 64'(x - x1) : 64'(x1 - x);
    dym = y2 >= y1 ? 64'(y2 - y1) : 64'(y1 - y2);
    den = x2 >= x1 ? 64'(x2 - x1) : 64'(x1 - x2);
    neg = ((x < x1) != (y2 < y1)) != (x2 < x1);
    prod = dxm * dym;
    q = prod / den;
    if (prod == 0) neg = 1'b0;
    if (neg) begin
      if (prod % den != 0) q = q + 1;
      return q >= 64'(y1) ? 32'd0 : 32'(64'(y1) - q);
    end
    if (q > 64'hffffffff || 64'(y1) + q > 64'hffffffff) return 32'hffffffff;
    return 32'(64'(y1) + q);
  endfunction

  function automatic logic [47:0] mean_int(longint acc);
    logic [63:0] mag;
    logic [63:0] lim;
    lim = (64'd1 << 47) - 1;
    mag = acc < 0 ? 64'd0 - 64'(acc) : 64'(acc);
    mag = mag >> 17;
    if (acc >= 0) return 48'(mag > lim ? lim : mag);
    if (mag > lim + 1) mag = lim + 1;
    return 48'(64'd0 - mag);
  endfunction

  task automatic sampler_predict(logic [1:0] op, logic [31:0] v, logic [31:0] c,
                                 logic [15:0] d);
    result_t     r;
    logic [63:0] s, dm, x64;
    longint      term;
    logic [31:0] x, x1, y1;
    logic        hit;
    r.value = '0;
    if (op == OP_CLEAR) begin
      n_pts = 0; span_lo = 0; span_hi = CDF_ONE; mean_acc = 0; prev_v = 0; prev_c = 0;
      r.status = ST_ACC;
    end else if (op == OP_APPEND) begin
      if (n_pts >= TABLE_DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        s = 64'(v) + 64'(prev_v);
        dm = c >= prev_c ? 64'(c - prev_c) : 64'(prev_c - c);
        if (s != 0 && dm > 64'(I64_MAX) / s) term = I64_MAX;
        else term = longint'(s * dm);
        if (c < prev_c) term = -term;
        if (term > 0 && mean_acc > I64_MAX - term) mean_acc = I64_MAX;
        else if (term < 0 && mean_acc < I64_MIN - term) mean_acc = I64_MIN;
        else mean_acc = mean_acc + term;
        prev_v = v; prev_c = c;
        tab_val[n_pts] = v; tab_cdf[n_pts] = c;
        n_pts++;
        if (c < span_lo) span_lo = c;
        if (c > span_hi) span_hi = c;
        r.status = ST_ACC;
      end
    end else if (n_pts == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Op 3 lands here too: only bit 1 selects a sample.
      x64 = (64'(d) * 64'(span_hi - span_lo)) / 64'd65535;
      x = span_lo + 32'(x64);
      x1 = 0; y1 = 0; hit = 1'b0;
      for (int i = 0; i < n_pts; i++) begin
        if (!hit && x <= tab_cdf[i]) begin
          r.value = lerp(x, x1, y1, tab_cdf[i], tab_val[i]);
          hit = 1'b1;
        end
        if (!hit) begin x1 = tab_cdf[i]; y1 = tab_val[i]; end
      end
      if (!hit) r.value = tab_val[n_pts-1];
      r.status = ST_OK;
    end
    r.cnt = 9'(n_pts);
    r.mean = mean_int(mean_acc);
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      n_pts = 0; span_lo = 0; span_hi = CDF_ONE; mean_acc = 0; prev_v = 0; prev_c = 0;
      expected_q.delete();
      fail_count <= 0; samples_seen <= 0; fulls_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_ch.status), 64'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.sample_value !== e.value)
            report_mismatch("sample_value", 64'(out_ch.sample_value), 64'(e.value));
          if (out_ch.status !== e.status)
            report_mismatch("status", 64'(out_ch.status), 64'(e.status));
          if (out_ch.entry_count !== e.cnt)
            report_mismatch("entry_count", 64'(out_ch.entry_count), 64'(e.cnt));
          if (out_ch.mean_value !== e.mean)
            report_mismatch("mean_value", 64'(out_ch.mean_value), 64'(e.mean));
          if (e.status == ST_OK) samples_seen <= samples_seen + 1;
          if (e.status == ST_FULL) fulls_seen <= fulls_seen + 1;
        end
      end
      if (in_ch.valid && in_ch.ready)
        sampler_predict(in_ch.op, in_ch.entry_value, in_ch.entry_cdf, in_ch.draw);
    end
  end
endmodule

// File: verif/tb.sv
// Top of the sampler testbench: clock, reset, stimulus and verdict.
// Depends on cdfs_pkg, cdfs_if, cdfs_checker and the sampler top level.
`timescale 1ns / 100ps
module tb;
  import cdfs_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending, samples_seen, fulls_seen;
  int   items_sent;
  logic hold_off;

  cdfs_in_if  in_ch ();
  cdfs_out_if out_ch ();

  cdf_table_random_sampler_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  cdfs_checker u_chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                      .fail_count(fail_count), .pending(pending),
                      .samples_seen(samples_seen), .fulls_seen(fulls_seen));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one beat with an optional random gap before it and waits for acceptance.
  task automatic send_beat(logic [1:0] op, logic [31:0] v, logic [31:0] c, logic [15:0] d,
                           bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.entry_value <= v;
    in_ch.entry_cdf <= c;
    in_ch.draw <= d;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    int wait_cycles;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [31:0] cdf_run;
    int          npts, drain;
    bit          gaps;
    items_sent = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_CLEAR;
    in_ch.entry_value = '0;
    in_ch.entry_cdf = '0;
    in_ch.draw = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, equal cdfs, decreasing cdfs, op 3, past the end.
    send_beat(OP_SAMPLE, '0, '0, 16'hffff);
    send_beat(2'd3, '0, '0, '0);
    send_beat(OP_APPEND, 32'd100, 32'd0, '0);
    send_beat(OP_APPEND, 32'd300, 32'd0, '0);
    send_beat(OP_APPEND, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_beat(OP_APPEND, 32'd5, 32'd20000, '0);
    send_beat(OP_SAMPLE, '0, '0, 16'd0);
    send_beat(OP_SAMPLE, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_beat(OP_SAMPLE, '0, '0, 16'h8000);
    send_beat(2'd3, '0, '0, 16'h0001);
    send_beat(OP_CLEAR, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_beat(OP_APPEND, 32'd1000, 32'd30000, '0);
    send_beat(OP_APPEND, 32'd10, 32'd10000, '0);
    send_beat(OP_SAMPLE, '0, '0, 16'hffff);
    send_beat(OP_SAMPLE, '0, '0, 16'h4000);
    send_beat(OP_SAMPLE, '0, '0, 16'h7fff);
    send_beat(OP_CLEAR, '0, '0, '0);
    send_beat(OP_APPEND, 32'd50, 32'd65536, '0);
    send_beat(OP_SAMPLE, '0, '0, 16'h5555);

    // Fill the table to overflow, with the receiver held off at the start.
    send_beat(OP_CLEAR, '0, '0, '0);
    hold_off = 1'b1;
    for (int i = 0; i < 258; i++) begin
      gaps = (i > 8);
      send_beat(OP_APPEND, rnd_val(), 32'(i * 256), '0, gaps);
    end
    for (int i = 0; i < 20; i++) send_beat(OP_SAMPLE, '0, '0, 16'($urandom));

    // Random part: mostly monotone tables of random size, then samples; some noise.
    while (items_sent < 1100) begin
      send_beat(OP_CLEAR, '0, '0, '0);
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      cdf_run = $urandom_range(0, 2000);
      for (int i = 0; i < npts; i++) begin
        if ($urandom_range(0, 7) == 0) cdf_run = $urandom;
        else cdf_run = cdf_run + $urandom_range(0, 20000);
        send_beat(OP_APPEND, rnd_val(), cdf_run, 16'($urandom));
      end
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(2'($urandom), $urandom, $urandom, 16'($urandom));
        else
          send_beat(OP_SAMPLE, $urandom, $urandom, 16'($urandom));
      end
    end
    in_ch.valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (600) @(posedge clk);
    $display("Sent %0d items; %0d samples checked, %0d full-table appends seen.",
             items_sent, samples_seen, fulls_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/cdfs_pkg.sv
hdl/cdfs_if.sv
hdl/cdfs_div.sv
hdl/cdf_table_random_sampler_unit.sv
hdl/cdfs_checker.sv
verif/cdfs_tb_if.sv
verif/cdfs_checker.sv
verif/tb.sv
